/* design/cdsg_pkg.sv */
package cdsg_pkg;

  // Sizing
  localparam int MAX_RESULTS = 64;
  localparam int COORD_WIDTH = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int LEN_W       = 24;
  localparam int SAT_W       = 50;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  // Thresholds in raw Q16.16 units
  localparam logic [LEN_W:0] SMALL_Q = 25'd6;
  localparam logic [LEN_W:0] HALF_Q  = 25'd32768;

  // Register indexes (paddr[2])
  localparam logic REG_DASH_LENGTH = 1'b0;
  localparam logic REG_DASH_GAP    = 1'b1;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic               final_pair;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_start_z;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] seg_end_z;
    logic               last_of_pair;
    logic               set_end;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       sq_en;
    logic [1:0] sq_idx;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic [1:0] div_comp;
    logic       loop_init;
    logic       adv_pair;
    logic       adv_tail;
    logic       mul_en;
    logic [1:0] mul_ph;
    logic [2:0] mul_idx;
    logic       push_a;
    logic       push_b;
    logic       push_line;
    logic       flush;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic len_small;
    logic gap_small;
    logic lenq_small;
    logic loop_go;
    logic tail_go;
  } stat_t;

  // Clamp to the signed coordinate range, keep the 32-bit field
  function automatic logic signed [31:0] sat_coord(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    logic signed [SAT_W-1:0] c;
    hi = SAT_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    lo = -hi - SAT_W'(1);
    if (v > hi) c = hi;
    else if (v < lo) c = lo;
    else c = v;
    return c[31:0];
  endfunction

endpackage

/* design/cdsg_regs.sv */
module cdsg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cdsg_pkg::ADDR_W-1:0] paddr,
  input  logic [cdsg_pkg::DATA_W-1:0] pwdata,
  output logic [cdsg_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output logic [cdsg_pkg::LEN_W-1:0]  dash_length,
  output logic [cdsg_pkg::LEN_W-1:0]  gap_length
);
  import cdsg_pkg::*;

  logic [LEN_W-1:0] dash_length_r;
  logic [LEN_W-1:0] gap_length_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Take register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dash_length_r <= 24'd26214;
      gap_length_r  <= 24'd22938;
    end else if (wr_en) begin
      case (paddr[2])
        REG_DASH_LENGTH: dash_length_r <= pwdata[LEN_W-1:0];
        REG_DASH_GAP:    gap_length_r  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      REG_DASH_LENGTH: prdata = DATA_W'(dash_length_r);
      REG_DASH_GAP:    prdata = DATA_W'(gap_length_r);
      default:         prdata = '0;
    endcase
  end

  assign dash_length = dash_length_r;
  assign gap_length  = gap_length_r;

endmodule

/* design/cdsg_ctrl.sv */
module cdsg_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  cdsg_pkg::stat_t stat,
  output cdsg_pkg::cmd_t  cmd,
  output logic            busy
);
  import cdsg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_ROOT, S_CHECK, S_DIV, S_LOOP, S_PROJ, S_EMIT_A, S_EMIT_B, S_FLUSH
  } state_t;

  state_t           state_r;
  logic [5:0]       cnt_r;
  logic [2:0]       sub_r;
  logic [1:0]       comp_r;
  logic [CNT_W-1:0] k_r;
  logic             tail_r;
  logic             room;

  assign room = k_r < CNT_W'(MAX_RESULTS);
  assign busy = state_r != S_IDLE;

  // Sequence one point pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sub_r   <= '0;
      comp_r  <= '0;
      k_r     <= '0;
      tail_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          k_r   <= '0;
          if (start) state_r <= S_SQ;
        end
        S_SQ: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd3) begin
            cnt_r   <= '0;
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd32) state_r <= S_CHECK;
        end
        S_CHECK: begin
          cnt_r  <= '0;
          comp_r <= '0;
          if (stat.len_small) state_r <= S_FLUSH;
          else if (!stat.gap_small) state_r <= S_DIV;
          else begin
            if (!stat.lenq_small) k_r <= k_r + CNT_W'(1);
            state_r <= S_FLUSH;
          end
        end
        S_DIV: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd32) begin
            cnt_r <= '0;
            if (comp_r == 2'd2) state_r <= S_LOOP;
            else comp_r <= comp_r + 2'd1;
          end
        end
        S_LOOP: begin
          cnt_r <= '0;
          sub_r <= '0;
          if (stat.loop_go && room) begin
            tail_r  <= 1'b0;
            state_r <= S_PROJ;
          end else if (room && stat.tail_go) begin
            tail_r  <= 1'b1;
            state_r <= S_PROJ;
          end else begin
            state_r <= S_FLUSH;
          end
        end
        S_PROJ: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd2) begin
            cnt_r <= '0;
            if (sub_r == 3'd5) state_r <= S_EMIT_A;
            else sub_r <= sub_r + 3'd1;
          end
        end
        S_EMIT_A: begin
          if (room) k_r <= k_r + CNT_W'(1);
          state_r <= S_EMIT_B;
        end
        S_EMIT_B: begin
          if (room) k_r <= k_r + CNT_W'(1);
          state_r <= tail_r ? S_FLUSH : S_LOOP;
        end
        S_FLUSH: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Decode datapath commands
  always_comb begin
    cmd          = '0;
    cmd.sq_idx   = cnt_r[1:0];
    cmd.div_comp = comp_r;
    cmd.mul_ph   = cnt_r[1:0];
    cmd.mul_idx  = sub_r;
    case (state_r)
      S_IDLE:   cmd.load = start;
      S_SQ:     cmd.sq_en = 1'b1;
      S_ROOT: begin
        cmd.sqrt_init = cnt_r == 6'd0;
        cmd.sqrt_step = cnt_r != 6'd0;
      end
      S_CHECK: begin
        cmd.loop_init = !stat.len_small && !stat.gap_small;
        cmd.push_line = !stat.len_small && stat.gap_small && !stat.lenq_small;
      end
      S_DIV: begin
        cmd.div_init = cnt_r == 6'd0;
        cmd.div_step = cnt_r != 6'd0;
      end
      S_LOOP: begin
        cmd.adv_pair = stat.loop_go && room;
        cmd.adv_tail = !(stat.loop_go && room) && room && stat.tail_go;
      end
      S_PROJ:   cmd.mul_en = 1'b1;
      S_EMIT_A: cmd.push_a = room;
      S_EMIT_B: cmd.push_b = room;
      S_FLUSH:  cmd.flush = 1'b1;
      default: ;
    endcase
  end

endmodule

/* design/cdsg_dpath.sv */
module cdsg_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cdsg_pkg::in_item_t        in_data,
  input  logic [cdsg_pkg::LEN_W-1:0] dash_length,
  input  logic [cdsg_pkg::LEN_W-1:0] gap_length,
  input  cdsg_pkg::cmd_t            cmd,
  output cdsg_pkg::stat_t           stat,
  output logic                      out_valid,
  output cdsg_pkg::out_item_t       out_data
);
  import cdsg_pkg::*;

  in_item_t           in_r;
  logic signed [31:0] mid_r [3];
  logic [31:0]        am_r [3];
  logic               neg_r [3];
  logic               shift_r;
  logic [63:0]        sq_r;
  logic [63:0]        sum_r;
  logic [63:0]        x_r;
  logic [33:0]        srem_r;
  logic [31:0]        root_r;
  logic [33:0]        drem_r;
  logic [31:0]        dq_r;
  logic [31:0]        q_r;
  logic [31:0]        um_r [3];
  logic [32:0]        l_left_r;
  logic [32:0]        l_used_r;
  logic [33:0]        t1_r;
  logic [33:0]        t2_r;
  logic [48:0]        pp_r;
  logic [48:0]        acc_r;
  logic [35:0]        proj_r [6];
  out_item_t          hold_r;
  logic               hold_v_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic [33:0]        len;
  logic [LEN_W:0]     period;
  logic [LEN_W:0]     sum_lg;
  logic [LEN_W-2:0]   hgap;
  logic [31:0]        sq_in;
  logic [35:0]        srem2;
  logic [33:0]        trial;
  logic [34:0]        drem2;
  logic [1:0]         mcomp;
  logic [33:0]        mt;
  logic [65:0]        prod;
  logic signed [31:0] sa [3];
  logic signed [31:0] sb [3];
  logic signed [31:0] ma [3];
  logic signed [31:0] mb [3];
  out_item_t          seg;

  // Component views of the input item
  assign pa[0] = in_data.start_x;
  assign pa[1] = in_data.start_y;
  assign pa[2] = in_data.start_z;
  assign pb[0] = in_data.end_x;
  assign pb[1] = in_data.end_y;
  assign pb[2] = in_data.end_z;

  // Period, half gap and length
  assign sum_lg = {1'b0, dash_length} + {1'b0, gap_length};
  assign period = (sum_lg <= SMALL_Q) ? HALF_Q : sum_lg;
  assign hgap   = gap_length[LEN_W-1:1];
  assign len    = shift_r ? {root_r, 2'b00} : {2'b00, root_r};

  assign stat.len_small  = len <= 34'(SMALL_Q);
  assign stat.gap_small  = {1'b0, gap_length} <= SMALL_Q;
  assign stat.lenq_small = {1'b0, dash_length} <= SMALL_Q;
  assign stat.loop_go    = l_left_r > 33'(period);
  assign stat.tail_go    = l_left_r > 33'(gap_length);

  // Square operand, one component a step
  always_comb begin
    case (cmd.sq_idx)
      2'd0:    sq_in = shift_r ? (am_r[0] >> 2) : am_r[0];
      2'd1:    sq_in = shift_r ? (am_r[1] >> 2) : am_r[1];
      2'd2:    sq_in = shift_r ? (am_r[2] >> 2) : am_r[2];
      default: sq_in = '0;
    endcase
  end

  // Root and divide digit steps
  assign srem2 = {srem_r, x_r[63:62]};
  assign trial = {root_r, 2'b01};
  assign drem2 = {drem_r, dq_r[31]};

  // Projection operands
  assign mcomp = (cmd.mul_idx < 3'd3) ? cmd.mul_idx[1:0] : 2'(cmd.mul_idx - 3'd3);
  assign mt    = (cmd.mul_idx < 3'd3) ? t1_r : t2_r;
  assign prod  = 66'(acc_r) + (66'(pp_r) << 17) + (66'd1 << 29);

  // Dash ends and their mirrors through the midpoint
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [SAT_W-1:0] m;
      logic signed [SAT_W-1:0] v1;
      logic signed [SAT_W-1:0] v2;
      m  = SAT_W'(mid_r[i]);
      v1 = SAT_W'(proj_r[i]);
      v2 = SAT_W'(proj_r[i+3]);
      if (neg_r[i]) begin
        v1 = -v1;
        v2 = -v2;
      end
      sa[i] = sat_coord(m + v1);
      sb[i] = sat_coord(m + v2);
      ma[i] = sat_coord(m - v1);
      mb[i] = sat_coord(m - v2);
    end
  end

  // Select the segment to push
  always_comb begin
    seg = '0;
    if (cmd.push_line) begin
      seg.seg_start_x = sat_coord(SAT_W'(in_r.start_x));
      seg.seg_start_y = sat_coord(SAT_W'(in_r.start_y));
      seg.seg_start_z = sat_coord(SAT_W'(in_r.start_z));
      seg.seg_end_x   = sat_coord(SAT_W'(in_r.end_x));
      seg.seg_end_y   = sat_coord(SAT_W'(in_r.end_y));
      seg.seg_end_z   = sat_coord(SAT_W'(in_r.end_z));
    end else if (cmd.push_a) begin
      seg.seg_start_x = sa[0];
      seg.seg_start_y = sa[1];
      seg.seg_start_z = sa[2];
      seg.seg_end_x   = sb[0];
      seg.seg_end_y   = sb[1];
      seg.seg_end_z   = sb[2];
    end else begin
      seg.seg_start_x = ma[0];
      seg.seg_start_y = ma[1];
      seg.seg_start_z = ma[2];
      seg.seg_end_x   = mb[0];
      seg.seg_end_y   = mb[1];
      seg.seg_end_z   = mb[2];
    end
  end

  // Arithmetic registers
  always_ff @(posedge clk) begin
    // Latch the pair, differences and midpoint
    if (cmd.load) begin
      logic big;
      big = 1'b0;
      in_r <= in_data;
      for (int i = 0; i < 3; i++) begin
        logic signed [32:0] d;
        logic signed [32:0] s;
        d = 33'(pb[i]) - 33'(pa[i]);
        s = 33'(pa[i]) + 33'(pb[i]);
        neg_r[i] <= d < 0;
        am_r[i]  <= d < 0 ? 32'(-d) : d[31:0];
        mid_r[i] <= s[32:1];
        if (d >= 33'sd2147483648 || d <= -33'sd2147483648) big = 1'b1;
      end
      shift_r <= big;
    end

    // Accumulate squares
    if (cmd.sq_en) begin
      sq_r  <= sq_in * sq_in;
      sum_r <= (cmd.sq_idx == 2'd0) ? '0 : sum_r + sq_r;
    end

    // Square root, one bit a step
    if (cmd.sqrt_init) begin
      x_r    <= sum_r;
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      x_r <= x_r << 2;
      if (srem2 >= 36'(trial)) begin
        srem_r <= 34'(srem2 - 36'(trial));
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        srem_r <= srem2[33:0];
        root_r <= {root_r[30:0], 1'b0};
      end
    end

    // Unit vector, one quotient bit a step
    if (cmd.div_init) begin
      drem_r <= 34'(am_r[cmd.div_comp] >> 2);
      dq_r   <= {am_r[cmd.div_comp][1:0], 30'd0};
      q_r    <= '0;
    end else if (cmd.div_step) begin
      dq_r <= dq_r << 1;
      if (drem2 >= 35'(len)) begin
        drem_r               <= 34'(drem2 - 35'(len));
        q_r                  <= {q_r[30:0], 1'b1};
        um_r[cmd.div_comp]   <= {q_r[30:0], 1'b1};
      end else begin
        drem_r               <= drem2[33:0];
        q_r                  <= {q_r[30:0], 1'b0};
        um_r[cmd.div_comp]   <= {q_r[30:0], 1'b0};
      end
    end

    // Walk outward from the midpoint
    if (cmd.loop_init) begin
      l_left_r <= len[33:1];
      l_used_r <= '0;
    end else if (cmd.adv_pair) begin
      t1_r     <= 34'(l_used_r) + 34'(hgap);
      t2_r     <= 34'(l_used_r) + 34'(dash_length) + 34'(hgap);
      l_left_r <= l_left_r - 33'(period);
      l_used_r <= l_used_r + 33'(period);
    end else if (cmd.adv_tail) begin
      t1_r <= 34'(l_used_r) + 34'(hgap);
      t2_r <= 34'(l_used_r) + 34'(l_left_r - 33'(gap_length)) + 34'(hgap);
    end

    // Project distances on the unit vector, two partial products each
    if (cmd.mul_en) begin
      case (cmd.mul_ph)
        2'd0: pp_r <= 49'(um_r[mcomp] * mt[16:0]);
        2'd1: begin
          acc_r <= pp_r;
          pp_r  <= 49'(um_r[mcomp] * mt[33:17]);
        end
        2'd2: proj_r[cmd.mul_idx] <= prod[65:30];
        default: ;
      endcase
    end
  end

  // Hold one segment back so the last one can be flagged
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cmd.push_a || cmd.push_b || cmd.push_line) begin
        hold_r   <= seg;
        hold_v_r <= 1'b1;
        if (hold_v_r) begin
          out_valid_r <= 1'b1;
          out_data_r  <= hold_r;
        end
      end else if (cmd.flush && hold_v_r) begin
        hold_v_r                <= 1'b0;
        out_valid_r             <= 1'b1;
        out_data_r              <= hold_r;
        out_data_r.last_of_pair <= 1'b1;
        out_data_r.set_end      <= in_r.final_pair;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/centered_dash_segment_generator.sv */
// Channel  | Ports                                          | Direction
// ---------+------------------------------------------------+----------
// input    | start, busy, in_data                           | in/out
// result   | out_valid, out_data                            | out
// config   | psel, penable, pwrite, paddr, pwdata, prdata,  | in/out
//          | pready                                         |
//
// Per pair, the length comes from the squares, then a bit-serial root, and is
// then tested; unless length or gap is small, the three unit components go
// through one shared restoring divider, then each mirrored dash pair takes six
// projections on one multiplier in two partial products each, then one flush.
// Reset (rst_n low, synchronous) restores the default dash and gap.
// busy is high from the cycle after start and falls in the cycle that carries
// the last item; results are strobed on out_valid and the receiver cannot stall.
module centered_dash_segment_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  cdsg_pkg::in_item_t          in_data,
  output logic                        out_valid,
  output cdsg_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cdsg_pkg::ADDR_W-1:0] paddr,
  input  logic [cdsg_pkg::DATA_W-1:0] pwdata,
  output logic [cdsg_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import cdsg_pkg::*;

  logic [LEN_W-1:0] dash_length;
  logic [LEN_W-1:0] gap_length;
  cmd_t             cmd;
  stat_t            stat;
  logic             start_q;

  assign start_q = start & ~busy;

  cdsg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .dash_length (dash_length),
    .gap_length  (gap_length)
  );

  cdsg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_q),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  cdsg_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .dash_length (dash_length),
    .gap_length  (gap_length),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

/* tb/tb_centered_dash_segment_generator.sv */
module tb_centered_dash_segment_generator;
  import cdsg_pkg::*;

  // Segment predictor plus queue of expected segments
  class dash_board;
    longint unsigned cur_dash;
    longint unsigned cur_gap;
    out_item_t       pending_segs[$];
    out_item_t       pair_segs[$];
    int              n_errors;
    int              n_checked;

    function new();
      cur_dash  = 26214;
      cur_gap   = 22938;
      n_errors  = 0;
      n_checked = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == REG_DASH_LENGTH) cur_dash = val[23:0];
      else cur_gap = val[23:0];
    endfunction

    function longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function longint floor_half(longint x);
      return (x >= 0) ? x / 2 : -((-x + 1) / 2);
    endfunction

    function void add_seg(longint a[3], longint b[3]);
      out_item_t s;
      s.seg_start_x  = clamp32(a[0]);
      s.seg_start_y  = clamp32(a[1]);
      s.seg_start_z  = clamp32(a[2]);
      s.seg_end_x    = clamp32(b[0]);
      s.seg_end_y    = clamp32(b[1]);
      s.seg_end_z    = clamp32(b[2]);
      s.last_of_pair = 1'b0;
      s.set_end      = 1'b0;
      pair_segs.push_back(s);
    endfunction

    // Emit the dash from t1 to t2 and its mirror through the midpoint
    function void add_mirrored(longint mid[3], longint unsigned unit[3], bit ng[3],
                               longint t1, longint t2);
      longint pa[3], pb[3], ma[3], mb[3];
      longint q1, q2;
      for (int i = 0; i < 3; i++) begin
        q1 = longint'((unsigned'(t1) * unit[i] + (64'd1 << 29)) >> 30);
        q2 = longint'((unsigned'(t2) * unit[i] + (64'd1 << 29)) >> 30);
        if (ng[i]) begin
          q1 = -q1;
          q2 = -q2;
        end
        pa[i] = mid[i] + q1;
        pb[i] = mid[i] + q2;
        ma[i] = mid[i] - q1;
        mb[i] = mid[i] - q2;
      end
      if (pair_segs.size() < MAX_RESULTS) add_seg(pa, pb);
      if (pair_segs.size() < MAX_RESULTS) add_seg(ma, mb);
    endfunction

    // Note an accepted item: work out every segment it causes
    function void note_pair(in_item_t it);
      longint p1[3], p2[3], mid[3];
      longint unsigned am[3], unit[3];
      longint unsigned sum, len, s;
      bit ng[3];
      longint period, lenq, gapq, hgap, left, used;
      int sh;
      p1 = '{longint'(it.start_x), longint'(it.start_y), longint'(it.start_z)};
      p2 = '{longint'(it.end_x), longint'(it.end_y), longint'(it.end_z)};
      pair_segs.delete();
      for (int i = 0; i < 3; i++) begin
        ng[i]  = p2[i] < p1[i];
        am[i]  = ng[i] ? unsigned'(p1[i] - p2[i]) : unsigned'(p2[i] - p1[i]);
        mid[i] = floor_half(p1[i] + p2[i]);
      end
      sh = (am[0] >= 64'h80000000 || am[1] >= 64'h80000000 || am[2] >= 64'h80000000) ? 2 : 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        s = am[i] >> sh;
        sum += s * s;
      end
      len = root_floor(sum) << sh;
      lenq = longint'(cur_dash);
      gapq = longint'(cur_gap);
      period = lenq + gapq;
      if (period <= 6) period = 32768;
      if (len > 6) begin
        if (gapq > 6) begin
          for (int i = 0; i < 3; i++) unit[i] = (am[i] << 30) / len;
          hgap = gapq / 2;
          left = longint'(len >> 1);
          used = 0;
          while (left > period && pair_segs.size() < MAX_RESULTS) begin
            add_mirrored(mid, unit, ng, used + hgap, used + lenq + hgap);
            left -= period;
            used += period;
          end
          if (pair_segs.size() < MAX_RESULTS && left > gapq) begin
            left -= gapq;
            add_mirrored(mid, unit, ng, used + hgap, used + left + hgap);
          end
        end else if (lenq > 6) begin
          add_seg(p1, p2);
        end
      end
      if (pair_segs.size() > 0) begin
        pair_segs[pair_segs.size()-1].last_of_pair = 1'b1;
        pair_segs[pair_segs.size()-1].set_end      = it.final_pair;
      end
      foreach (pair_segs[i]) pending_segs.push_back(pair_segs[i]);
    endfunction

    // Compare a strobed segment with the oldest expected one
    function void check_seg(out_item_t got);
      out_item_t w;
      if (pending_segs.size() == 0) begin
        $error("segment with none expected: %p", got);
        n_errors++;
        return;
      end
      w = pending_segs.pop_front();
      n_checked++;
      if (got.seg_start_x !== w.seg_start_x) begin
        $error("seg_start_x exp %0d got %0d", w.seg_start_x, got.seg_start_x); n_errors++;
      end
      if (got.seg_start_y !== w.seg_start_y) begin
        $error("seg_start_y exp %0d got %0d", w.seg_start_y, got.seg_start_y); n_errors++;
      end
      if (got.seg_start_z !== w.seg_start_z) begin
        $error("seg_start_z exp %0d got %0d", w.seg_start_z, got.seg_start_z); n_errors++;
      end
      if (got.seg_end_x !== w.seg_end_x) begin
        $error("seg_end_x exp %0d got %0d", w.seg_end_x, got.seg_end_x); n_errors++;
      end
      if (got.seg_end_y !== w.seg_end_y) begin
        $error("seg_end_y exp %0d got %0d", w.seg_end_y, got.seg_end_y); n_errors++;
      end
      if (got.seg_end_z !== w.seg_end_z) begin
        $error("seg_end_z exp %0d got %0d", w.seg_end_z, got.seg_end_z); n_errors++;
      end
      if (got.last_of_pair !== w.last_of_pair) begin
        $error("last_of_pair exp %0b got %0b", w.last_of_pair, got.last_of_pair); n_errors++;
      end
      if (got.set_end !== w.set_end) begin
        $error("set_end exp %0b got %0b", w.set_end, got.set_end); n_errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_data;
  logic                out_valid;
  out_item_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  dash_board board;
  int        idle_pct;
  int        n_pairs;
  int        n_cycles;

  centered_dash_segment_generator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Observe accepted items and strobed segments
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        board.note_pair(in_data);
        n_pairs++;
      end
      if (out_valid) board.check_seg(out_data);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > 3000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle
  task automatic reg_write(logic idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    board.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait for the block to drain, then load a new dash and gap
  task automatic set_dashes(logic [23:0] dl, logic [23:0] dg);
    start <= 1'b0;
    @(posedge clk);
    while (busy || board.pending_segs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    reg_write(REG_DASH_LENGTH, {8'd0, dl});
    reg_write(REG_DASH_GAP, {8'd0, dg});
  endtask

  // Hold an item on the input until it is taken, then idle at random
  task automatic send_pair(in_item_t it);
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  function automatic in_item_t make_pair(longint ax, longint ay, longint az,
                                         longint bx, longint by, longint bz, bit fin);
    in_item_t it;
    it.start_x = ax[31:0]; it.start_y = ay[31:0]; it.start_z = az[31:0];
    it.end_x = bx[31:0]; it.end_y = by[31:0]; it.end_z = bz[31:0];
    it.final_pair = fin;
    return it;
  endfunction

  // Random pair: mostly lines a few dozen periods long, some full range, some degenerate
  function automatic in_item_t rand_pair();
    in_item_t it;
    int sel;
    longint span, c[3], d[3];
    sel = $urandom_range(99);
    span = (board.cur_dash + board.cur_gap + 1) * longint'($urandom_range(40, 1));
    if (span > 64'sd1000000000) span = 64'sd1000000000;
    for (int i = 0; i < 3; i++) begin
      c[i] = longint'($signed($urandom_range(2097152))) - 1048576;
      d[i] = longint'($urandom_range(32'(span))) - span / 2;
    end
    if (sel < 12) begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0};
    end else if (sel < 18) begin
      it = make_pair(c[0], c[1], c[2], c[0] + $urandom_range(3), c[1], c[2], 1'b0);
    end else begin
      it = make_pair(c[0], c[1], c[2], c[0] + d[0], c[1] + d[1], c[2] + d[2], 1'b0);
    end
    it.final_pair = $urandom_range(1);
    return it;
  endfunction

  // Directed corners, run under the current dash setting
  task automatic directed_pairs();
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 1));
    send_pair(make_pair(0, 0, 0, 6, 0, 0, 1));
    send_pair(make_pair(0, 0, 0, 7, 0, 0, 1));
    send_pair(make_pair(0, 0, 0, 327680, 0, 0, 1));
    send_pair(make_pair(327680, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(0, 65536, -65536, 0, -262144, 131072, 1));
    send_pair(make_pair(-3, -5, 1, 100003, 4, -99999, 1));
    send_pair(make_pair(-2147483648, -2147483648, -2147483648,
                        2147483647, 2147483647, 2147483647, 1));
    send_pair(make_pair(2147483647, 0, -2147483648, -2147483648, 5, 2147483647, 0));
    send_pair(make_pair(2147483647, 2147483647, 2147483647,
                        2147483647, 2147483647, 2147483647, 1));
  endtask

  initial begin
    board    = new();
    n_pairs  = 0;
    n_cycles = 0;
    idle_pct = 0;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset dashes, no gap, both small, maximum lengths
    directed_pairs();
    set_dashes(24'd65536, 24'd0);
    directed_pairs();
    set_dashes(24'd0, 24'd0);
    directed_pairs();
    set_dashes(24'hFFFFFF, 24'hFFFFFF);
    directed_pairs();
    set_dashes(24'd7, 24'd7);
    send_pair(make_pair(0, 0, 0, 40000, 30000, 0, 1));

    // Random phases with varied idling and dash settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 77;
        2: idle_pct = 0;
        default: idle_pct = 12;
      endcase
      case (ph)
        0: set_dashes(24'd26214, 24'd22938);
        1: set_dashes(24'(($urandom_range(200000))), 24'(($urandom_range(200000))));
        2: set_dashes(24'd0, 24'd65536);
        3: set_dashes(24'hFFFFFF, 24'd7);
        4: set_dashes(24'd100000, 24'd6);
        5: set_dashes(24'(($urandom)), 24'(($urandom)));
        6: set_dashes(24'd3, 24'd3);
        default: set_dashes(24'(($urandom_range(100000))), 24'(($urandom_range(100000))));
      endcase
      for (int k = 0; k < 35; k++) send_pair(rand_pair());
    end

    start <= 1'b0;
    @(posedge clk);
    while (busy || board.pending_segs.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d point pairs and %0d dash segments over thirteen dash settings,",
             n_pairs, board.n_checked);
    $display("with zero, small, maximum and random dash and gap lengths.");
    if (board.n_errors == 0 && board.pending_segs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
